/* sv/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(label, clk_sig, rstn_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) else $error(msg);

// Concurrent assertion on the block clock clk and reset arst_n.
`define ASSERT_STD(label, prop, msg) \
	`ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

/* sv/vwpe_pkg.sv */
// Package with types, constants and the palette table of the pixel expander.
package vwpe_pkg;

	// Pixels produced from one video word, and the beat counter that walks them.
	localparam int unsigned PX_PER_WORD = 16;
	localparam int unsigned CNT_W = $clog2(PX_PER_WORD);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PX_PER_WORD - 1);

	typedef logic [CNT_W-1:0] beat_cnt_t;
	typedef logic [15:0] rgb565_t;
	typedef logic [3:0] pal_row_t;
	typedef logic [2:0] entry_t;

	// Palette entries with a fixed meaning in every row.
	localparam entry_t ENTRY_BLACK = 3'd0;
	localparam entry_t ENTRY_WHITE = 3'd4;

	// RGB565 colors.
	localparam rgb565_t K_BLACK = 16'h0000;
	localparam rgb565_t K_WHITE = 16'hffff;
	localparam rgb565_t K_RED   = 16'hf800;
	localparam rgb565_t K_GREEN = 16'h07e0;
	localparam rgb565_t K_BLUE  = 16'h001f;
	localparam rgb565_t K_YEL   = K_RED | K_GREEN;
	localparam rgb565_t K_MAG   = K_RED | K_BLUE;
	localparam rgb565_t K_CYAN  = K_GREEN | K_BLUE;

	// Configuration port: address width and register indexes.
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic REG_COLOR_MODE = 1'b0;

	// Four-color entries of each palette row; the first entry is black in every row.
	localparam rgb565_t PALETTE_ROM [16][4] = '{
		'{K_BLACK, K_BLUE,  K_GREEN, K_RED  },
		'{K_BLACK, K_YEL,   K_MAG,   K_RED  },
		'{K_BLACK, K_CYAN,  K_BLUE,  K_MAG  },
		'{K_BLACK, K_GREEN, K_CYAN,  K_YEL  },
		'{K_BLACK, K_MAG,   K_CYAN,  K_WHITE},
		'{K_BLACK, K_WHITE, K_WHITE, K_WHITE},
		'{K_BLACK, K_RED,   K_YEL,   K_RED  },
		'{K_BLACK, K_GREEN, K_CYAN,  K_YEL  },
		'{K_BLACK, K_CYAN,  K_BLUE,  K_MAG  },
		'{K_BLACK, K_YEL,   K_BLUE,  K_RED  },
		'{K_BLACK, K_YEL,   K_CYAN,  K_RED  },
		'{K_BLACK, K_CYAN,  K_YEL,   K_RED  },
		'{K_BLACK, K_RED,   K_GREEN, K_CYAN },
		'{K_BLACK, K_CYAN,  K_YEL,   K_WHITE},
		'{K_BLACK, K_YEL,   K_GREEN, K_WHITE},
		'{K_BLACK, K_CYAN,  K_GREEN, K_WHITE}
	};

	// Color of one palette entry in one row.
	function automatic rgb565_t palette_lookup(input pal_row_t row, input entry_t entry);
		rgb565_t color;
		case (entry)
			3'd0, 3'd1, 3'd2, 3'd3: color = PALETTE_ROM[row][entry[1:0]];
			ENTRY_WHITE: color = K_WHITE;
			default: color = K_BLACK;
		endcase
		return color;
	endfunction

endpackage

/* sv/video_word_palette_pixel_expander.sv */
// A transferred word is held in the word register; each of its pixels then passes
// stage 1, stage 2 and stage 3. Throughput: one pixel per cycle unless out_ready
// stalls the pipeline; the next word is taken in the cycle the current word issues
// its sixteenth pixel. The rate is set by the beat counter that walks the 16 pixels
// of a word. Reset (arst_n low) clears all valid bits and sets color_mode to 0.
`include "assert_macros.svh"

module video_word_palette_pixel_expander (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [vwpe_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// Input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [15:0]                      video_word,
	input  logic [3:0]                       palette_index,
	// Output channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [15:0]                      pixel_color,
	output logic                             last_of_word
);

	logic                  color_mode_q;
	logic                  cfg_wr;
	logic                  reg_sel;

	logic                  busy_q;
	logic                  mode_q;
	logic [15:0]           word_q;
	vwpe_pkg::pal_row_t    row_q;
	vwpe_pkg::beat_cnt_t   cnt_q;

	logic                  vld_s1;
	vwpe_pkg::entry_t      entry_s1;
	vwpe_pkg::pal_row_t    row_s1;
	logic                  last_s1;

	logic                  vld_s2;
	vwpe_pkg::rgb565_t     color_s2;
	logic                  last_s2;

	logic                  vld_s3;
	vwpe_pkg::rgb565_t     color_s3;
	logic                  last_s3;

	logic                  adv1;
	logic                  adv2;
	logic                  adv3;
	logic                  beat_fire;
	logic                  beat_last;
	logic                  in_fire;
	vwpe_pkg::entry_t      beat_entry;

	// Configuration register access.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (cfg_wr && reg_sel == vwpe_pkg::REG_COLOR_MODE) begin
			color_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel == vwpe_pkg::REG_COLOR_MODE) begin
			prdata = {31'd0, color_mode_q};
		end
	end

	// Pipeline advance: a stage moves when it is empty or the next one moves.
	assign adv3 = !vld_s3 || out_ready;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign beat_fire = busy_q && adv1;
	assign beat_last = cnt_q == vwpe_pkg::CNT_LAST;
	assign in_ready  = !busy_q || (beat_fire && beat_last);
	assign in_fire   = in_valid && in_ready;

	// Word register and beat counter that issue one pixel per cycle while stage 1 can advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (in_fire) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (beat_fire) begin
			busy_q <= !beat_last;
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_q <= video_word;
			row_q  <= palette_index;
			mode_q <= color_mode_q;
		end
	end

	// Palette entry of the current beat: a bit pair in color mode, one bit in mono.
	always_comb begin
		if (mode_q) begin
			beat_entry = {1'b0, word_q[{cnt_q[3:1], 1'b1}], word_q[{cnt_q[3:1], 1'b0}]};
		end else if (word_q[cnt_q]) begin
			beat_entry = vwpe_pkg::ENTRY_WHITE;
		end else begin
			beat_entry = vwpe_pkg::ENTRY_BLACK;
		end
	end

	// Stage 1: entry, row and last flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv1) begin
			vld_s1 <= beat_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_fire) begin
			entry_s1 <= beat_entry;
			row_s1   <= row_q;
			last_s1  <= beat_last;
		end
	end

	// Stage 2: palette table lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && vld_s1) begin
			color_s2 <= vwpe_pkg::palette_lookup(row_s1, entry_s1);
			last_s2  <= last_s1;
		end
	end

	// Stage 3: output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && vld_s2) begin
			color_s3 <= color_s2;
			last_s3  <= last_s2;
		end
	end

	assign out_valid    = vld_s3;
	assign pixel_color  = color_s3;
	assign last_of_word = last_s3;

	// A new word always starts at its first beat.
	`ASSERT_STD(a_word_start, in_fire |=> busy_q && cnt_q == '0, "word did not start at beat zero")
	// The last flag entering stage 1 matches the beat that produced it.
	`ASSERT_STD(a_last_flag, beat_fire |=> vld_s1 && last_s1 == $past(beat_last), "last flag mismatch")
	// In color mode both beats of a pixel select the same entry.
	`ASSERT_STD(a_color_pair, beat_fire && mode_q && cnt_q[0] |-> entry_s1 == beat_entry, "color pixel pair differs")

endmodule
